[rtl/assert_macros.svh]
// Assertion macros shared by the pricer RTL.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication.
`define APBP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define APBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/apbp_pkg.sv]
// Shared types, codes and helpers for the American put binomial pricer.
// Used by apbp_ctrl, apbp_dp and the top level; depends on nothing.
package apbp_pkg;

  localparam int MAX_STEPS_DEF = 64;
  localparam int DIV_STEPS     = 31;
  localparam int CNT_W         = 5;

  typedef struct packed {
    logic [31:0] spot_price;
    logic [31:0] strike_price;
    logic [31:0] up_factor;
    logic [31:0] down_factor;
    logic [30:0] step_rate;
    logic [6:0]  step_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] option_price;
    logic        status;
  } out_item_t;

  typedef enum logic [2:0] {
    MUL_UP,
    MUL_DN,
    MUL_PV,
    MUL_QV,
    MUL_DSC
  } mul_op_t;

  typedef enum logic [1:0] {
    RES_BAD,
    RES_PAY0,
    RES_NODE
  } res_sel_t;

  typedef enum logic {
    DIV_PROB,
    DIV_DISC
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_init;
    div_sel_t div_sel;
    logic     div_step;
    logic     div_first;
    logic     p_st;
    logic     d_st;
    logic     s_wr_s0;
    logic     s_wr_acc;
    logic     s_rd_fw;
    logic     s_rd_bk;
    logic     v_wr_exp;
    logic     v_wr_node;
    logic     v_rd_first;
    logic     v_rd_next;
    logic     va_ld;
    logic     mul_en;
    mul_op_t  mul_op;
    logic     acc_en;
    logic     acc_add;
    logic     e_cap;
    logic     res_cap;
    res_sel_t res_sel;
    logic     fw_init;
    logic     fw_adv;
    logic     bk_adv;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic zero_steps;
    logic j_eq_t;
    logic t_eq_last;
    logic lvl_zero;
    logic j_eq_lvl;
  } stat_t;

  function automatic logic [31:0] put_payoff(input logic [31:0] k, input logic [31:0] s);
    put_payoff = (k > s) ? (k - s) : 32'd0;
  endfunction

endpackage

[rtl/apbp_dp.sv]
// Datapath: operand registers, divider, shared multiply-accumulate, lattice
// memories and loop counters. Uses apbp_pkg; driven by apbp_ctrl commands.
`include "assert_macros.svh"
module apbp_dp #(
  parameter int MAX_STEPS = apbp_pkg::MAX_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  apbp_pkg::in_item_t  in_data,
  input  apbp_pkg::cmd_t      cmd_i,
  output apbp_pkg::stat_t     stat_o,
  output apbp_pkg::out_item_t res_o
);
  import apbp_pkg::*;

  localparam int SW     = $clog2(MAX_STEPS + 1);
  localparam int SDEPTH = (MAX_STEPS + 1) * (MAX_STEPS + 2) / 2;
  localparam int AW     = $clog2(SDEPTH);

  logic [31:0] s_r, k_r, u_r, d_r;
  logic [32:0] gross_r;
  logic [SW-1:0] steps_r;
  logic [32:0] rem_r, den_r;
  logic [30:0] quo_r;
  logic [29:0] p_r;
  logic [30:0] disc_r;
  logic [63:0] prod_r, acc_r;
  logic [31:0] srd_r, vrd_r, va_r, e_r;
  logic [SW-1:0] t_r, j_r, lvl_r;
  logic [AW-1:0] base_r, waddr_r;
  out_item_t res_r;

  logic [31:0] stock_mem [0:SDEPTH-1];
  logic [31:0] value_mem [0:MAX_STEPS];

  logic [32:0] tmp;
  logic        qbit;
  logic [30:0] q_fac;
  logic [31:0] mul_a, mul_b;
  logic [31:0] acc_sat, node_val;
  logic [AW-1:0] s_raddr;
  logic [SW-1:0] v_raddr, v_waddr;
  logic [SW-1:0] steps_in;

  assign steps_in = (32'(in_data.step_count) > MAX_STEPS) ? SW'(MAX_STEPS)
                                                          : SW'(in_data.step_count);
  assign tmp      = cmd_i.div_first ? rem_r : {rem_r[31:0], 1'b0};
  assign qbit     = (tmp >= den_r);
  assign q_fac    = 31'(1 << 30) - {1'b0, p_r};
  assign acc_sat  = (|acc_r[63:62]) ? 32'hFFFF_FFFF : acc_r[61:30];
  assign node_val = (put_payoff(k_r, srd_r) > acc_sat) ? put_payoff(k_r, srd_r) : acc_sat;
  assign s_raddr  = cmd_i.s_rd_fw
                  ? base_r + AW'(stat_o.j_eq_t ? t_r - SW'(1) : j_r)
                  : base_r + AW'(j_r);
  assign v_raddr  = cmd_i.v_rd_first ? '0 : j_r + SW'(1);
  assign v_waddr  = j_r;

  assign stat_o.ok         = ({1'b0, d_r} < gross_r) && (gross_r < {1'b0, u_r});
  assign stat_o.zero_steps = (steps_r == '0);
  assign stat_o.j_eq_t     = (j_r == t_r);
  assign stat_o.t_eq_last  = (t_r == steps_r);
  assign stat_o.lvl_zero   = (lvl_r == '0);
  assign stat_o.j_eq_lvl   = (j_r == lvl_r);
  assign res_o             = res_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_UP: begin mul_a = srd_r; mul_b = u_r; end
      MUL_DN: begin mul_a = srd_r; mul_b = d_r; end
      MUL_PV: begin mul_a = va_r;  mul_b = {2'b0, p_r}; end
      MUL_QV: begin mul_a = vrd_r; mul_b = {1'b0, q_fac}; end
      MUL_DSC: begin mul_a = e_r;  mul_b = {1'b0, disc_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      s_r     <= in_data.spot_price;
      k_r     <= in_data.strike_price;
      u_r     <= in_data.up_factor;
      d_r     <= in_data.down_factor;
      gross_r <= 33'(1 << 30) + 33'(in_data.step_rate);
      steps_r <= steps_in;
    end
    if (cmd_i.div_init) begin
      quo_r <= '0;
      if (cmd_i.div_sel == DIV_PROB) begin
        rem_r <= gross_r - {1'b0, d_r};
        den_r <= {1'b0, u_r} - {1'b0, d_r};
      end else begin
        rem_r <= 33'(1 << 30);
        den_r <= gross_r;
      end
    end else if (cmd_i.div_step) begin
      rem_r <= qbit ? tmp - den_r : tmp;
      quo_r <= {quo_r[29:0], qbit};
    end
    if (cmd_i.p_st) p_r <= quo_r[29:0];
    if (cmd_i.d_st) disc_r <= quo_r;
    if (cmd_i.mul_en) prod_r <= 64'(mul_a) * 64'(mul_b);
    if (cmd_i.acc_en) acc_r <= (cmd_i.acc_add ? acc_r : 64'd0) + prod_r;
    if (cmd_i.e_cap) e_r <= acc_sat;
    if (cmd_i.va_ld) va_r <= vrd_r;
    if (cmd_i.res_cap) begin
      case (cmd_i.res_sel)
        RES_BAD:  res_r <= '{option_price: 32'd0, status: 1'b1};
        RES_PAY0: res_r <= '{option_price: put_payoff(k_r, s_r), status: 1'b0};
        RES_NODE: res_r <= '{option_price: node_val, status: 1'b0};
        default:  res_r <= '{option_price: 32'd0, status: 1'b1};
      endcase
    end
  end

  // Loop counters: t/j walk forward levels, lvl/j walk back to the root.
  always_ff @(posedge clk) begin
    if (cmd_i.fw_init) begin
      t_r     <= SW'(1);
      j_r     <= '0;
      waddr_r <= AW'(1);
      base_r  <= '0;
    end else if (cmd_i.fw_adv) begin
      waddr_r <= waddr_r + AW'(1);
      if (stat_o.j_eq_t) begin
        j_r <= '0;
        if (stat_o.t_eq_last) begin
          lvl_r <= t_r - SW'(1);
        end else begin
          base_r <= base_r + AW'(t_r);
          t_r    <= t_r + SW'(1);
        end
      end else begin
        j_r <= j_r + SW'(1);
      end
    end else if (cmd_i.bk_adv) begin
      if (stat_o.j_eq_lvl) begin
        j_r    <= '0;
        lvl_r  <= lvl_r - SW'(1);
        base_r <= base_r - AW'(lvl_r);
      end else begin
        j_r <= j_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.s_wr_s0) stock_mem[0] <= s_r;
    else if (cmd_i.s_wr_acc) stock_mem[waddr_r] <= acc_sat;
    if (cmd_i.s_rd_fw || cmd_i.s_rd_bk) srd_r <= stock_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.v_wr_exp) value_mem[v_waddr] <= put_payoff(k_r, acc_sat);
    else if (cmd_i.v_wr_node) value_mem[v_waddr] <= node_val;
    if (cmd_i.v_rd_first || cmd_i.v_rd_next) vrd_r <= value_mem[v_raddr];
  end

  `APBP_ASSERT_IMPL(a_fw_in_level, cmd_i.fw_adv, j_r <= t_r && t_r <= steps_r)
  `APBP_ASSERT_IMPL(a_bk_in_level, cmd_i.bk_adv, j_r <= lvl_r)
  `APBP_ASSERT_NEXT(a_prob_below_one, cmd_i.p_st, p_r < 30'h3FFF_FFFF || p_r == 30'h3FFF_FFFF)

endmodule

[rtl/apbp_ctrl.sv]
// Sequencer for the pricer: handshakes, division steps, forward stock fill
// and backward induction. Uses apbp_pkg; commands apbp_dp.
`include "assert_macros.svh"
module apbp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  apbp_pkg::stat_t stat_i,
  output apbp_pkg::cmd_t  cmd_o
);
  import apbp_pkg::*;

  typedef enum logic [4:0] {
    IDLE, CHECK, DIVP, PST, DIVD, DST, S0,
    FW_RD, FW_MUL, FW_ACC, FW_WR,
    BK_LV, BK_RD, BK_M1, BK_M2, BK_A2, BK_E, BK_M3, BK_A3, BK_WR,
    FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  res_sel_t   res_sel_r, res_sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd_o       = '0;
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    res_sel_nxt = res_sel_r;
    unique case (state_r)
      IDLE: if (in_valid) begin
        cmd_o.load = 1'b1;
        state_nxt  = CHECK;
      end
      CHECK: begin
        if (stat_i.ok) begin
          cmd_o.div_init = 1'b1;
          cmd_o.div_sel  = DIV_PROB;
          cnt_nxt        = '0;
          state_nxt      = DIVP;
        end else begin
          res_sel_nxt = RES_BAD;
          state_nxt   = FIN;
        end
      end
      DIVP, DIVD: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_r == '0);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == DIVP) ? PST : DST;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      PST: begin
        cmd_o.p_st     = 1'b1;
        cmd_o.div_init = 1'b1;
        cmd_o.div_sel  = DIV_DISC;
        state_nxt      = DIVD;
      end
      DST: begin
        cmd_o.d_st = 1'b1;
        state_nxt  = S0;
      end
      S0: begin
        cmd_o.s_wr_s0 = 1'b1;
        cmd_o.fw_init = 1'b1;
        if (stat_i.zero_steps) begin
          res_sel_nxt = RES_PAY0;
          state_nxt   = FIN;
        end else begin
          state_nxt = FW_RD;
        end
      end
      FW_RD: begin
        cmd_o.s_rd_fw = 1'b1;
        state_nxt     = FW_MUL;
      end
      FW_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = stat_i.j_eq_t ? MUL_DN : MUL_UP;
        state_nxt    = FW_ACC;
      end
      FW_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_nxt    = FW_WR;
      end
      FW_WR: begin
        cmd_o.s_wr_acc = 1'b1;
        cmd_o.v_wr_exp = stat_i.t_eq_last;
        cmd_o.fw_adv   = 1'b1;
        state_nxt = (stat_i.j_eq_t && stat_i.t_eq_last) ? BK_LV : FW_RD;
      end
      BK_LV: begin
        cmd_o.v_rd_first = 1'b1;
        state_nxt        = BK_RD;
      end
      BK_RD: begin
        // shift the old right child into the left slot, fetch the next one
        cmd_o.va_ld     = 1'b1;
        cmd_o.v_rd_next = 1'b1;
        cmd_o.s_rd_bk   = 1'b1;
        state_nxt       = BK_M1;
      end
      BK_M1: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_PV;
        state_nxt    = BK_M2;
      end
      BK_M2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_QV;
        cmd_o.acc_en = 1'b1;
        state_nxt    = BK_A2;
      end
      BK_A2: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_add = 1'b1;
        state_nxt     = BK_E;
      end
      BK_E: begin
        cmd_o.e_cap = 1'b1;
        state_nxt   = BK_M3;
      end
      BK_M3: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_DSC;
        state_nxt    = BK_A3;
      end
      BK_A3: begin
        cmd_o.acc_en = 1'b1;
        state_nxt    = BK_WR;
      end
      BK_WR: begin
        cmd_o.v_wr_node = 1'b1;
        cmd_o.bk_adv    = 1'b1;
        if (stat_i.lvl_zero) begin
          res_sel_nxt = RES_NODE;
          state_nxt   = FIN;
        end else begin
          state_nxt = stat_i.j_eq_lvl ? BK_LV : BK_RD;
        end
      end
      FIN: if (!out_valid_r || out_ready) begin
        cmd_o.res_cap = 1'b1;
        cmd_o.res_sel = res_sel_r;
        state_nxt     = IDLE;
      end
      default: state_nxt = IDLE;
    endcase
    out_valid_nxt = cmd_o.res_cap ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      cnt_r       <= '0;
      res_sel_r   <= RES_BAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      res_sel_r   <= res_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `APBP_ASSERT_IMPL(a_cap_free, cmd_o.res_cap, !out_valid_r || out_ready)
  `APBP_ASSERT_NEXT(a_take_busy, in_valid && in_ready, !in_ready)
  `APBP_ASSERT_NEXT(a_cap_shows, cmd_o.res_cap, out_valid_r)

endmodule

[rtl/american_put_binomial_pricer.sv]
// American put on a recombining CRR lattice, one result per item.
// Two 31-step divisions, then each forward stock node is read, multiplied,
// accumulated and written; each backward node is a discounted weighted sum
// of its children held against early exercise, on one shared multiplier and
// one port of the stock memory. One item at a time; no clearing pass after
// reset. Synchronous active-low reset clears the sequencer and the output valid.
module american_put_binomial_pricer #(
  parameter int MAX_STEPS = apbp_pkg::MAX_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  apbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output apbp_pkg::out_item_t out_data
);
  import apbp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  apbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  apbp_dp #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .res_o   (out_data)
  );

endmodule

[tb/testbench.sv]
// Self-checking testbench for american_put_binomial_pricer: a predictor checks
// every result against a lattice evaluation. Needs apbp_pkg and the top level.
`timescale 1ns / 100ps

module testbench;
  import apbp_pkg::*;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_BAD_FACTORS = 1'b1;
  localparam int LONG_HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  in_item_t pending_items[$];
  out_item_t expected_prices[$];
  int items_queued = 0;
  int items_taken = 0;
  int prices_seen = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet = 1'b0;
  bit failed = 1'b0;

  american_put_binomial_pricer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] stock_move(logic [31:0] x, logic [31:0] f);
    logic [63:0] prod;
    prod = ({32'd0, x} * {32'd0, f}) >> 30;
    return (prod > {32'd0, SAT32}) ? SAT32 : prod[31:0];
  endfunction

  function automatic logic [31:0] exercise_value(logic [31:0] k, logic [31:0] s);
    return (k > s) ? k - s : 32'd0;
  endfunction

  function automatic out_item_t price_put(in_item_t it);
    logic [63:0] gross, prob, disc, e, c;
    logic [31:0] stocks[0:64];
    logic [31:0] vals[0:64];
    logic [31:0] x, y, es;
    int steps;
    out_item_t res;
    gross = ONE_Q30 + {33'd0, it.step_rate};
    steps = (it.step_count > 7'd64) ? 64 : int'(it.step_count);
    res = '0;
    if (!({32'd0, it.down_factor} < gross && gross < {32'd0, it.up_factor})) begin
      res.status = STATUS_BAD_FACTORS;
      return res;
    end
    prob = ((gross - {32'd0, it.down_factor}) << 30) /
           ({32'd0, it.up_factor} - {32'd0, it.down_factor});
    disc = (64'd1 << 60) / gross;
    stocks[0] = it.spot_price;
    for (int j = 1; j <= steps; j++) stocks[j] = stock_move(stocks[j-1], it.down_factor);
    for (int j = 0; j <= steps; j++) begin
      x = stocks[j];
      for (int n = j; n < steps; n++) x = stock_move(x, it.up_factor);
      vals[j] = exercise_value(it.strike_price, x);
    end
    for (int t = steps; t > 0; t--) begin
      for (int j = 0; j <= t - 1; j++) begin
        e = (prob * vals[j] + (ONE_Q30 - prob) * vals[j+1]) >> 30;
        es = (e > {32'd0, SAT32}) ? SAT32 : e[31:0];
        c = ({32'd0, es} * disc) >> 30;
        if (c > {32'd0, SAT32}) c = {32'd0, SAT32};
        x = stocks[j];
        for (int n = j; n < t - 1; n++) x = stock_move(x, it.up_factor);
        y = exercise_value(it.strike_price, x);
        vals[j] = (y > c[31:0]) ? y : c[31:0];
      end
    end
    res.option_price = vals[0];
    res.status = STATUS_OK;
    return res;
  endfunction

  task automatic queue_item(logic [31:0] s, logic [31:0] k, logic [31:0] u,
                            logic [31:0] d, logic [30:0] r, logic [6:0] t);
    in_item_t it;
    it.spot_price = s;
    it.strike_price = k;
    it.up_factor = u;
    it.down_factor = d;
    it.step_rate = r;
    it.step_count = t;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Well-formed request: d < 1+r < u, prices near each other unless wide, mostly short trees.
  task automatic queue_priced(bit wide);
    logic [31:0] s, k, u, d;
    logic [30:0] r;
    logic [6:0] t;
    logic [63:0] gross;
    r = wide ? 31'($urandom) : 31'($urandom_range(0, 32'h0040_0000));
    gross = ONE_Q30 + {33'd0, r};
    d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h3FFF_FFFF)
                                     : $urandom_range(32'h2000_0000, 32'h3FFF_FFFF);
    if (gross >= 64'h1_0000_0000 - 2) u = SAT32;
    else u = 32'(gross) + 32'd1 + $urandom_range(0, 32'h1000_0000);
    if (u <= gross[31:0]) u = SAT32;
    if (wide) begin
      s = $urandom;
      k = $urandom;
    end else begin
      s = $urandom_range(32'h0010_0000, 32'h0100_0000);
      k = s + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    end
    t = ($urandom_range(0, 49) == 0) ? 7'($urandom_range(64, 127))
                                     : 7'($urandom_range(0, 12));
    queue_item(s, k, u, d, r, t);
  endtask

  // Driver: hold the item until taken, then wait the drawn gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_prices.push_back(price_put(in_data));
        items_taken++;
      end
      if (in_valid && !in_ready) begin
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap <= quiet ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once, so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && prices_seen == 3) begin
      hold_left <= LONG_HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        prices_seen++;
        if (expected_prices.size() == 0) begin
          $error("unexpected result: option_price %h status %b",
                 out_data.option_price, out_data.status);
          failed = 1'b1;
        end else begin
          exp_res = expected_prices.pop_front();
          if (out_data.option_price !== exp_res.option_price) begin
            $error("option_price: expected %h actual %h",
                   exp_res.option_price, out_data.option_price);
            failed = 1'b1;
          end
          if (out_data.status !== exp_res.status) begin
            $error("status: expected %b actual %b", exp_res.status, out_data.status);
            failed = 1'b1;
          end
        end
        recv_gap <= quiet ? 0 : $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else if (hold_left > 0 || (!hold_done && prices_seen == 3)) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] hundred;
    hundred = 32'h0064_0000;
    // Directed: extremes, zero steps, invalid boundaries, overflow, saturation.
    queue_item(hundred, 32'h0078_0000, 32'h4800_0000, 32'h3800_0000, 31'd0, 7'd0);
    queue_item(hundred, 32'h0078_0000, 32'h4000_0000, 32'h3800_0000, 31'd0, 7'd0);
    queue_item(hundred, 32'h0064_0000, 32'h4400_0000, 32'h3C00_0000, 31'h0010_0000, 7'd3);
    queue_item(hundred, 32'h0064_0000, 32'h4400_0000, 32'h4010_0000, 31'h0010_0000, 7'd3);
    queue_item(hundred, 32'h0064_0000, 32'h4010_0000, 32'h3C00_0000, 31'h0010_0000, 7'd3);
    queue_item(hundred, 32'h0064_0000, 32'h4010_0001, 32'h400F_FFFF, 31'h0010_0000, 7'd2);
    queue_item(32'd0, SAT32, 32'h4800_0000, 32'h3800_0000, 31'd0, 7'd4);
    queue_item(SAT32, SAT32, SAT32, 32'h3F00_0000, 31'd0, 7'd5);
    queue_item(SAT32, 32'd0, SAT32, 32'd0, 31'h7FFF_FFFF, 7'd2);
    queue_item(32'h0000_0001, 32'h0000_0002, SAT32, 32'd0, 31'h7FFF_FFFF, 7'd6);
    queue_item(32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 7'd1);
    queue_item(hundred, 32'h0070_0000, 32'h4200_0000, 32'h3E00_0000, 31'h0001_0000, 7'd1);
    queue_item(hundred, 32'h0070_0000, 32'h4200_0000, 32'h3E00_0000, 31'h0001_0000, 7'd64);
    queue_item(hundred, 32'h0070_0000, 32'h4200_0000, 32'h3E00_0000, 31'h0001_0000, 7'd127);
    queue_item(hundred, 32'h0050_0000, 32'h4200_0000, 32'h3E00_0000, 31'h0001_0000, 7'd65);
    queue_item(32'h8000_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h2000_0000, 31'h0000_0100, 7'd8);
    for (int i = 0; i < 255; i++) begin
      if (i % 60 == 30) quiet = ~quiet;
      case ($urandom_range(0, 9))
        0: queue_item($urandom, $urandom, $urandom, $urandom, 31'($urandom),
                      7'($urandom_range(0, 10)));
        1, 2: queue_priced(1'b1);
        default: queue_priced(1'b0);
      endcase
      while (pending_items.size() > 8) @(posedge clk);
    end
    while (items_taken < items_queued || expected_prices.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("american_put_binomial_pricer regression: pass");
    end else begin
      $display("american_put_binomial_pricer regression: fail");
    end
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #40_000_000;
    $display("american_put_binomial_pricer regression: fail");
    $finish;
  end

endmodule
